[rtl/cse_pkg.sv]
// Shared op codes and COBS constants for the stream encoder.
`timescale 1ns / 1ps

package cse_pkg;

  // Op codes on the op field
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_END  = 2'd1;
  localparam logic [1:0] OP_PULL = 2'd2;

  // Largest length code; a block holds at most CODE_MAX - 1 data bytes
  localparam int CODE_MAX = 255;

  // Code written into the slot of a block closed by a zero right after a full one
  localparam logic [7:0] CODE_ONE = 8'd1;

  // Delimiter byte appended by an end op
  localparam logic [7:0] DELIM = 8'd0;

endpackage

[rtl/cobs_stream_encoder.sv]
// Top level of the streaming COBS encoder over a byte ring memory.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid / in_stall) carries op and data_byte. op push
//   stores a payload byte, op end closes the message and appends the 0x00
//   delimiter, op pull fetches the next finished encoded byte.
//   Output channel (res_valid / res_stall) carries one result per input
//   transaction: out_byte, out_valid (a pull returned a byte) and accepted
//   (a push or end found room in the ring and was stored).
// Timing:
//   After an input transaction is taken, the block holds in_stall high
//   while it does the second ring write of the item, if any, and until
//   the result register takes the item; no new transaction is taken
//   before then. The ring memory has a single write port; a push that
//   closes a full block, and an end, both need two writes.
//   While a result waits under res_stall, the next input is still taken;
//   it then holds in the busy state until the output register frees up.
// Reset:
//   rst clears the ring pointers (empty ring, first code slot reserved) and
//   drops res_valid. Ring contents need no clearing.

module cobs_stream_encoder
  import cse_pkg::*;
#(
  parameter int RING_DEPTH = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] data_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       accepted
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] LAST    = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_X = (PTR_W+1)'(RING_DEPTH);
  localparam logic [PTR_W-1:0] LEN_FULL = PTR_W'(CODE_MAX);
  localparam logic [PTR_W-1:0] FREE_2   = PTR_W'(2);
  localparam logic [PTR_W-1:0] FREE_3   = PTR_W'(3);

  // Pointers and control registers
  logic [PTR_W-1:0] rd_idx, wr_idx, code_idx;
  logic             busy;
  logic             w2_en;
  logic [PTR_W-1:0] w2_addr;
  logic [7:0]       w2_data;
  logic             pend_pull;
  logic             pend_acc;

  // Next values
  logic [PTR_W-1:0] rd_idx_next, wr_idx_next, code_idx_next;
  logic             w2_en_next;
  logic [PTR_W-1:0] w2_addr_next;
  logic [7:0]       w2_data_next;
  logic             pull_next, acc_next;

  // Ring port signals
  logic             w1_en;
  logic [PTR_W-1:0] w1_addr;
  logic [7:0]       w1_data;
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [7:0]       ram_rdata;

  logic             take;
  logic             out_free;
  logic [PTR_W-1:0] wr_inc1, wr_inc2, rd_inc;
  logic [PTR_W-1:0] free_slots, blk_len;
  logic [PTR_W:0]   free_diff, len_diff;
  logic             full_block;
  logic [7:0]       close_code;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_stall = busy;
  assign take     = in_valid && !busy;
  assign out_free = !res_valid || !res_stall;

  // Pointer arithmetic
  assign wr_inc1 = wrap_inc(wr_idx);
  assign wr_inc2 = wrap_inc(wr_inc1);
  assign rd_inc  = wrap_inc(rd_idx);

  assign free_diff  = {1'b0, rd_idx} - {1'b0, wr_idx};
  assign free_slots = (rd_idx >= wr_idx) ? free_diff[PTR_W-1:0]
                                         : PTR_W'(free_diff + DEPTH_X);
  assign len_diff   = {1'b0, wr_idx} - {1'b0, code_idx};
  assign blk_len    = (wr_idx >= code_idx) ? len_diff[PTR_W-1:0]
                                           : PTR_W'(len_diff + DEPTH_X);
  assign full_block = blk_len >= LEN_FULL;
  assign close_code = full_block ? 8'(CODE_MAX) : blk_len[7:0];

  // Decode one item: first write, second write, pointer updates
  always_comb begin
    rd_idx_next   = rd_idx;
    wr_idx_next   = wr_idx;
    code_idx_next = code_idx;
    w1_en         = 1'b0;
    w1_addr       = code_idx;
    w1_data       = close_code;
    w2_en_next    = 1'b0;
    w2_addr_next  = wr_idx;
    w2_data_next  = DELIM;
    pull_next     = 1'b0;
    acc_next      = 1'b0;
    case (op)
      OP_PUSH: begin
        if (full_block) begin
          if (free_slots >= FREE_3) begin
            // close the full block with the largest code, then place the byte (a zero writes CODE_ONE)
            acc_next   = 1'b1;
            w1_en      = 1'b1;
            w2_en_next = 1'b1;
            wr_idx_next = wr_inc2;
            if (data_byte == 8'd0) begin
              w2_addr_next  = wr_idx;
              w2_data_next  = CODE_ONE;
              code_idx_next = wr_inc1;
            end else begin
              w2_addr_next  = wr_inc1;
              w2_data_next  = data_byte;
              code_idx_next = wr_idx;
            end
          end
        end else if (free_slots >= FREE_2) begin
          acc_next    = 1'b1;
          w1_en       = 1'b1;
          wr_idx_next = wr_inc1;
          if (data_byte == 8'd0) begin
            // zero closes the block; its slot is the next code slot
            code_idx_next = wr_idx;
          end else begin
            w1_addr = wr_idx;
            w1_data = data_byte;
          end
        end
      end
      OP_END: begin
        if (free_slots >= FREE_3) begin
          acc_next      = 1'b1;
          w1_en         = 1'b1;
          w2_en_next    = 1'b1;
          w2_addr_next  = wr_idx;
          w2_data_next  = DELIM;
          code_idx_next = wr_inc1;
          wr_idx_next   = wr_inc2;
        end
      end
      OP_PULL: begin
        if (rd_idx != code_idx) begin
          pull_next   = 1'b1;
          rd_idx_next = rd_inc;
        end
      end
      default: begin
      end
    endcase
  end

  // Ring port steering: first write on the accept cycle, second one after
  assign ram_we    = take ? w1_en : (busy && w2_en);
  assign ram_waddr = take ? w1_addr : w2_addr;
  assign ram_wdata = take ? w1_data : w2_data;
  assign ram_re    = take && pull_next;

  cse_ring_ram #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // Pointers, item sequencing and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      wr_idx    <= PTR_W'(1);
      code_idx  <= '0;
      busy      <= 1'b0;
      w2_en     <= 1'b0;
      res_valid <= 1'b0;
      pend_pull <= 1'b0;
      pend_acc  <= 1'b0;
    end else begin
      // result register: load the finished item, or drop a taken result
      if (busy && out_free) begin
        res_valid <= 1'b1;
        out_byte  <= pend_pull ? ram_rdata : 8'd0;
        out_valid <= pend_pull;
        accepted  <= pend_acc;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (take) begin
        rd_idx    <= rd_idx_next;
        wr_idx    <= wr_idx_next;
        code_idx  <= code_idx_next;
        busy      <= 1'b1;
        w2_en     <= w2_en_next;
        w2_addr   <= w2_addr_next;
        w2_data   <= w2_data_next;
        pend_pull <= pull_next;
        pend_acc  <= acc_next;
      end else if (busy) begin
        w2_en <= 1'b0;
        if (out_free) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[rtl/cse_ring_ram.sv]
// Byte ring memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module cse_ring_ram #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
